>>> rtl/core/sedt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedt_pkg: shared types and constants for the scope edge trigger decimator
// Field widths, register indexes, the decimation factor table and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sedt_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int FACTOR_W   = 16;
  localparam int SUM_W      = 24;
  localparam int DVD_W      = SUM_W + 1;   // sum plus one more sample
  localparam int Q_W        = 8;           // quotient bits, saturated to 255
  localparam int CAP_W      = 11;
  localparam int DIDX_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int STEP_W     = 4;

  localparam logic [SAMPLE_W-1:0] HYSTERESIS = 8'd30;
  localparam logic [STEP_W-1:0]   DIV_FIRST_STEP = 4'd8;  // overflow check step

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_CHANNEL = 3'd0,
    CFG_TRIG_LEVEL   = 3'd1,
    CFG_TRIG_FALLING = 3'd2,
    CFG_DEC_INDEX    = 3'd3,
    CFG_AVG_MODE     = 3'd4,
    CFG_CAP_PAIRS    = 3'd5
  } cfg_reg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted input pair
    logic proc;       // evaluate trigger / decimation, update state
    logic div_start;  // launch the averaging divider
    logic push;       // load the output register
  } dp_cmd_t;

  // Datapath -> controller (valid during proc)
  typedef struct packed {
    logic emit;
    logic use_div;
  } dp_sts_t;

  // Decimation factor table; index 15 is treated as 14
  function automatic logic [FACTOR_W-1:0] factor_lookup(input logic [DIDX_W-1:0] idx);
    logic [FACTOR_W-1:0] f;
    begin
      unique case (idx)
        4'd0:    f = 16'd0;
        4'd1:    f = 16'd2;
        4'd2:    f = 16'd5;
        4'd3:    f = 16'd10;
        4'd4:    f = 16'd20;
        4'd5:    f = 16'd50;
        4'd6:    f = 16'd100;
        4'd7:    f = 16'd200;
        4'd8:    f = 16'd500;
        4'd9:    f = 16'd1000;
        4'd10:   f = 16'd2000;
        4'd11:   f = 16'd5000;
        4'd12:   f = 16'd10000;
        4'd13:   f = 16'd20000;
        default: f = 16'd50000;
      endcase
      return f;
    end
  endfunction

endpackage

>>> rtl/core/sedt_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedt_divider: two-lane serial divider for capture averages
// Restoring division of a 25-bit sum by the 16-bit factor, one quotient bit
// per cycle. First step checks sum >= factor*256 and saturates to 255.
// ----------------------------------------------------------------------------
module sedt_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sedt_pkg::DVD_W-1:0]     dvd_a,
  input  logic [sedt_pkg::DVD_W-1:0]     dvd_b,
  input  logic [sedt_pkg::FACTOR_W-1:0]  divisor,
  output logic                           done,
  output logic [sedt_pkg::Q_W-1:0]       q_a,
  output logic [sedt_pkg::Q_W-1:0]       q_b
);

  logic                          busy_r;
  logic [sedt_pkg::STEP_W-1:0]   step_r;
  logic [sedt_pkg::FACTOR_W-1:0] div_r;
  logic [sedt_pkg::DVD_W-1:0]    rem_r [2];
  logic [sedt_pkg::Q_W-1:0]      q_r   [2];
  logic                          sat_r [2];

  logic [sedt_pkg::DVD_W-1:0]    dsh;
  logic                          ge    [2];

  assign dsh = {{(sedt_pkg::DVD_W - sedt_pkg::FACTOR_W){1'b0}}, div_r} << step_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ge[l] = (rem_r[l] >= dsh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= sedt_pkg::DIV_FIRST_STEP;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r    <= divisor;
      rem_r[0] <= dvd_a;
      rem_r[1] <= dvd_b;
      for (int l = 0; l < 2; l++) begin
        q_r[l]   <= '0;
        sat_r[l] <= 1'b0;
      end
    end else if (busy_r) begin
      for (int l = 0; l < 2; l++) begin
        if (step_r == sedt_pkg::DIV_FIRST_STEP) begin
          if (ge[l]) begin
            sat_r[l] <= 1'b1;
          end
        end else begin
          q_r[l] <= {q_r[l][sedt_pkg::Q_W-2:0], ge[l]};
          if (ge[l]) begin
            rem_r[l] <= rem_r[l] - dsh;
          end
        end
      end
    end
  end

  assign done = busy_r && (step_r == '0);
  assign q_a  = sat_r[0] ? '1 : q_r[0];
  assign q_b  = sat_r[1] ? '1 : q_r[1];

endmodule

>>> rtl/core/sedt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedt_datapath: trigger, decimation and capture state
// Config registers, hysteresis edge detector, decimation counter, channel
// sums, capture length counter and output register.
// ----------------------------------------------------------------------------
module sedt_datapath #(
  parameter int MAX_PAIRS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sedt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sedt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [sedt_pkg::SAMPLE_W-1:0]     in_ch1,
  input  logic [sedt_pkg::SAMPLE_W-1:0]     in_ch2,
  input  sedt_pkg::dp_cmd_t                 cmd,
  output sedt_pkg::dp_sts_t                 sts,
  output logic [sedt_pkg::DVD_W-1:0]        div_dvd_a,
  output logic [sedt_pkg::DVD_W-1:0]        div_dvd_b,
  output logic [sedt_pkg::FACTOR_W-1:0]     div_divisor,
  input  logic [sedt_pkg::Q_W-1:0]          div_q_a,
  input  logic [sedt_pkg::Q_W-1:0]          div_q_b,
  output logic [sedt_pkg::SAMPLE_W-1:0]     out_ch1,
  output logic [sedt_pkg::SAMPLE_W-1:0]     out_ch2,
  output logic                              out_last
);

  localparam int PW = $clog2(MAX_PAIRS + 1);
  localparam int LW = (PW > sedt_pkg::CAP_W) ? PW : sedt_pkg::CAP_W;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_HIGH = 2'd1,
    EDGE_LOW  = 2'd2
  } edge_t;

  // config
  logic                          trig_ch_r;
  logic [sedt_pkg::SAMPLE_W-1:0] level_r;
  logic                          falling_r;
  logic [sedt_pkg::DIDX_W-1:0]   dec_idx_r;
  logic                          avg_r;
  logic [sedt_pkg::CAP_W-1:0]    cap_pairs_r;

  // input pair
  logic [sedt_pkg::SAMPLE_W-1:0] a_r, b_r;

  // capture state
  logic [1:0]                    edge_r, edge_nxt;
  logic                          capturing_r, capturing_nxt;
  logic [sedt_pkg::FACTOR_W-1:0] dcount_r, dcount_nxt;
  logic [sedt_pkg::SUM_W-1:0]    sum1_r, sum1_nxt, sum2_r, sum2_nxt;
  logic [PW-1:0]                 pairs_r, pairs_nxt;

  // result staging and output register
  logic [sedt_pkg::SAMPLE_W-1:0] res1_r, res2_r;
  logic                          last_r, use_div_r;
  logic [sedt_pkg::SAMPLE_W-1:0] out1_r, out2_r;
  logic                          olast_r;

  // combinational
  logic [sedt_pkg::FACTOR_W-1:0] factor;
  logic [sedt_pkg::SAMPLE_W-1:0] s, hi, lo;
  logic [sedt_pkg::SAMPLE_W:0]   lvl_sum;
  logic                          is_hi, is_lo, fire, active, emit, use_div, last;
  logic [sedt_pkg::FACTOR_W-1:0] dc_eff, dc_tmp, dc_inc;
  logic [sedt_pkg::SUM_W-1:0]    sum1_eff, sum2_eff;
  logic [sedt_pkg::DVD_W-1:0]    acc1, acc2;
  logic [PW-1:0]                 pairs_eff, pairs_inc;
  logic [LW-1:0]                 cap_w, limit;

  function automatic logic [sedt_pkg::FACTOR_W-1:0] sat_inc(
    input logic [sedt_pkg::FACTOR_W-1:0] v);
    begin
      return (v == '1) ? v : v + 1'b1;
    end
  endfunction

  // ---- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ch_r   <= 1'b0;
      level_r     <= 8'd128;
      falling_r   <= 1'b0;
      dec_idx_r   <= '0;
      avg_r       <= 1'b0;
      cap_pairs_r <= 11'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sedt_pkg::CFG_TRIG_CHANNEL: trig_ch_r   <= cfg_wdata[0];
        sedt_pkg::CFG_TRIG_LEVEL:   level_r     <= cfg_wdata[sedt_pkg::SAMPLE_W-1:0];
        sedt_pkg::CFG_TRIG_FALLING: falling_r   <= cfg_wdata[0];
        sedt_pkg::CFG_DEC_INDEX:    dec_idx_r   <= cfg_wdata[sedt_pkg::DIDX_W-1:0];
        sedt_pkg::CFG_AVG_MODE:     avg_r       <= cfg_wdata[0];
        sedt_pkg::CFG_CAP_PAIRS:    cap_pairs_r <= cfg_wdata[sedt_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- thresholds and edge detector
  assign factor  = sedt_pkg::factor_lookup(dec_idx_r);
  assign s       = trig_ch_r ? b_r : a_r;
  assign lvl_sum = {1'b0, level_r} + {1'b0, sedt_pkg::HYSTERESIS};

  always_comb begin
    if (falling_r) begin
      lo = level_r;
      hi = lvl_sum[sedt_pkg::SAMPLE_W] ? '1 : lvl_sum[sedt_pkg::SAMPLE_W-1:0];
    end else begin
      hi = level_r;
      lo = (level_r >= sedt_pkg::HYSTERESIS) ? level_r - sedt_pkg::HYSTERESIS : '0;
    end
  end

  assign is_hi = (s >= hi);
  assign is_lo = (s <= lo);

  // ---- per-item evaluation
  always_comb begin
    edge_nxt      = edge_r;
    capturing_nxt = capturing_r;
    dcount_nxt    = dcount_r;
    sum1_nxt      = sum1_r;
    sum2_nxt      = sum2_r;
    pairs_nxt     = pairs_r;
    fire          = 1'b0;
    emit          = 1'b0;
    use_div       = 1'b0;
    last          = 1'b0;
    dc_tmp        = '0;

    if (!capturing_r) begin
      unique case (edge_r)
        EDGE_NONE: begin
          if (is_hi)      edge_nxt = EDGE_HIGH;
          else if (is_lo) edge_nxt = EDGE_LOW;
        end
        EDGE_LOW: begin
          if (is_hi) begin
            if (!falling_r) fire = 1'b1;
            else            edge_nxt = EDGE_HIGH;
          end
        end
        EDGE_HIGH: begin
          if (!is_hi && is_lo) begin
            if (falling_r) fire = 1'b1;
            else           edge_nxt = EDGE_LOW;
          end
        end
        default: edge_nxt = edge_r;
      endcase
    end

    active    = capturing_r || fire;
    dc_eff    = capturing_r ? dcount_r : (avg_r ? '0 : factor);
    sum1_eff  = capturing_r ? sum1_r : '0;
    sum2_eff  = capturing_r ? sum2_r : '0;
    pairs_eff = capturing_r ? pairs_r : '0;
    dc_inc    = sat_inc(dc_eff);
    acc1      = {1'b0, sum1_eff} + {{(sedt_pkg::DVD_W - sedt_pkg::SAMPLE_W){1'b0}}, a_r};
    acc2      = {1'b0, sum2_eff} + {{(sedt_pkg::DVD_W - sedt_pkg::SAMPLE_W){1'b0}}, b_r};
    pairs_inc = pairs_eff + 1'b1;

    cap_w = LW'(cap_pairs_r);
    if (cap_w == '0)                 limit = LW'(1);
    else if (cap_w > LW'(MAX_PAIRS)) limit = LW'(MAX_PAIRS);
    else                             limit = cap_w;

    if (active) begin
      if (fire) edge_nxt = EDGE_NONE;
      capturing_nxt = 1'b1;
      sum1_nxt      = sum1_eff;
      sum2_nxt      = sum2_eff;
      pairs_nxt     = pairs_eff;

      if (!avg_r) begin
        if (dc_eff >= factor) begin
          emit   = 1'b1;
          dc_tmp = '0;
        end else begin
          dc_tmp = dc_eff;
        end
        dcount_nxt = sat_inc(dc_tmp);
      end else begin
        dcount_nxt = dc_inc;
        if (factor == '0) begin
          emit = 1'b1;
        end else if (dc_inc >= factor) begin
          emit       = 1'b1;
          use_div    = 1'b1;
          dcount_nxt = '0;
        end else begin
          sum1_nxt = acc1[sedt_pkg::SUM_W] ? '1 : acc1[sedt_pkg::SUM_W-1:0];
          sum2_nxt = acc2[sedt_pkg::SUM_W] ? '1 : acc2[sedt_pkg::SUM_W-1:0];
        end
      end

      if (emit) begin
        sum1_nxt  = '0;
        sum2_nxt  = '0;
        pairs_nxt = pairs_inc;
        last      = (LW'(pairs_inc) >= limit);
        if (last) begin
          capturing_nxt = 1'b0;
          edge_nxt      = EDGE_NONE;
        end
      end
    end
  end

  assign sts.emit    = emit;
  assign sts.use_div = use_div;
  assign div_dvd_a   = acc1;
  assign div_dvd_b   = acc2;
  assign div_divisor = factor;

  // ---- state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r      <= EDGE_NONE;
      capturing_r <= 1'b0;
      dcount_r    <= '0;
      sum1_r      <= '0;
      sum2_r      <= '0;
      pairs_r     <= '0;
    end else if (cmd.proc) begin
      edge_r      <= edge_nxt;
      capturing_r <= capturing_nxt;
      dcount_r    <= dcount_nxt;
      sum1_r      <= sum1_nxt;
      sum2_r      <= sum2_nxt;
      pairs_r     <= pairs_nxt;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_ch1;
      b_r <= in_ch2;
    end
    if (cmd.proc) begin
      res1_r    <= a_r;
      res2_r    <= b_r;
      last_r    <= last;
      use_div_r <= use_div;
    end
    if (cmd.push) begin
      out1_r  <= use_div_r ? div_q_a : res1_r;
      out2_r  <= use_div_r ? div_q_b : res2_r;
      olast_r <= last_r;
    end
  end

  assign out_ch1  = out1_r;
  assign out_ch2  = out2_r;
  assign out_last = olast_r;

endmodule

>>> rtl/core/sedt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedt_ctrl: item sequencer
// Accept, evaluate, optional divide, hand result to the output register.
// ----------------------------------------------------------------------------
module sedt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sedt_pkg::dp_sts_t sts,
  input  logic              div_done,
  output sedt_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_DIV,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (!sts.emit) begin
          state_nxt = S_IDLE;
        end else if (sts.use_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/core/scope_edge_trigger_decimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_trigger_decimator_top: two-channel edge trigger with decimation
// Stream in sample pairs, stream out decimated or averaged capture pairs.
// ----------------------------------------------------------------------------
// Usage: while armed, each input pair is checked against a hysteresis edge
// trigger on the selected channel; pairs that do not fire produce no item.
// Once fired, the capture emits capture_pairs result items (sample mode keeps
// the trigger pair then every factor-th pair; average mode emits the mean of
// each group of factor pairs), the final one with out_tlast set, after which
// the trigger re-arms. A pair that yields no result passes through accept and
// evaluate; a kept pair through accept, evaluate and load output; an
// averaged result also waits on the serial divider between evaluate and load
// (one overflow check plus 8 quotient bits, both channels in parallel). The
// output register holds one finished item, so the next pair is accepted
// while it waits on out_tready; a further result holds in the load step
// until that register frees.
// Config writes (cfg_we) take effect immediately; write only between items.
// ----------------------------------------------------------------------------
module scope_edge_trigger_decimator_top #(
  parameter int MAX_PAIRS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,

  // input pairs
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [7:0] ch1_sample, [15:8] ch2_sample

  // results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] out_ch1, [15:8] out_ch2
  output logic                            out_tlast,  // last_of_capture

  // config write port
  input  logic                            cfg_we,
  input  logic [sedt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sedt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sedt_pkg::dp_cmd_t             cmd;
  sedt_pkg::dp_sts_t             sts;
  logic                          div_done;
  logic [sedt_pkg::DVD_W-1:0]    dvd_a, dvd_b;
  logic [sedt_pkg::FACTOR_W-1:0] divisor;
  logic [sedt_pkg::Q_W-1:0]      q_a, q_b;
  logic [sedt_pkg::SAMPLE_W-1:0] o1, o2;

  // Sequencer: one item at a time through accept / evaluate / divide / push
  sedt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .div_done   (div_done),
    .cmd        (cmd)
  );

  // Trigger, counters, sums, config and output register
  sedt_datapath #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_ch1      (in_tdata[7:0]),
    .in_ch2      (in_tdata[15:8]),
    .cmd         (cmd),
    .sts         (sts),
    .div_dvd_a   (dvd_a),
    .div_dvd_b   (dvd_b),
    .div_divisor (divisor),
    .div_q_a     (q_a),
    .div_q_b     (q_b),
    .out_ch1     (o1),
    .out_ch2     (o2),
    .out_last    (out_tlast)
  );

  // Serial divider for averaged results, launched from the evaluate cycle
  sedt_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dvd_a   (dvd_a),
    .dvd_b   (dvd_b),
    .divisor (divisor),
    .done    (div_done),
    .q_a     (q_a),
    .q_b     (q_b)
  );

  assign out_tdata = {o2, o1};

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scope_edge_trigger_decimator_top
// Streams sample pairs through the edge trigger, predicts every capture
// result in-bench and compares each output item field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_PAIRS     = 1024;
  localparam int RANDOM_ITEMS  = 930;   // random part, after the directed cases
  // Margin for the block to finish its last item before config writes.
  localparam int DRAIN_CYCLES  = 32;
  // Longest legal quiet stretch: drain, 6 config writes, a sender gap, block
  // latency and a receiver stall; the limit below sits well above it.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int unsigned FACTORS [15] = '{0, 2, 5, 10, 20, 50, 100, 200, 500,
                                           1000, 2000, 5000, 10000, 20000, 50000};

  typedef logic [sedt_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       last;
  } capture_out_t;

  typedef enum logic [1:0] {SEEN_NONE, SEEN_HIGH, SEEN_LOW} trig_seen_t;
  typedef enum logic [1:0] {ZONE_LOW, ZONE_MID, ZONE_HIGH} trig_zone_t;

  // DUT ports; all inputs known from time zero
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [15:0]                     in_tdata  = '0;   // [7:0] ch1_sample, [15:8] ch2_sample
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;        // [7:0] out_ch1, [15:8] out_ch2
  logic                            out_tlast;        // last_of_capture
  logic                            cfg_we    = 1'b0;
  logic [sedt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  cfg_data_t                       cfg_wdata = '0;

  scope_edge_trigger_decimator_top #(.MAX_PAIRS(MAX_PAIRS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the registers and of the trigger/capture state
  // --------------------------------------------------------------------------
  logic        m_chan    = 1'b0;
  logic [7:0]  m_level   = 8'd128;
  logic        m_falling = 1'b0;
  logic [3:0]  m_didx    = 4'd0;
  logic        m_avg     = 1'b0;
  logic [10:0] m_cap     = 11'd1000;

  trig_seen_t  trig_seen  = SEEN_NONE;
  logic        cap_active = 1'b0;
  int unsigned decim      = 0;
  int unsigned acc1       = 0;
  int unsigned acc2       = 0;
  int unsigned sent       = 0;

  capture_out_t expected_q [$];
  logic [15:0]  pending_q  [$];

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int result_cnt   = 0;
  int capture_cnt  = 0;
  int error_cnt    = 0;
  int phase_cnt    = 0;

  // Hysteresis window for the current edge selection, clamped to 0..255
  function automatic void trigger_window(output int unsigned hi, output int unsigned lo);
    if (!m_falling) begin
      hi = 32'(m_level);
      lo = (m_level >= sedt_pkg::HYSTERESIS) ? m_level - sedt_pkg::HYSTERESIS : 0;
    end else begin
      lo = 32'(m_level);
      hi = (m_level + sedt_pkg::HYSTERESIS > 255) ? 255 : m_level + sedt_pkg::HYSTERESIS;
    end
  endfunction

  // Advance the shadow state by one accepted pair; queue the result if any.
  task automatic predict_pair(input logic [7:0] a, input logic [7:0] b);
    int unsigned factor, s, hi, lo, o1, o2, limit;
    logic fire, emit;
    capture_out_t r;
    factor = FACTORS[(m_didx > 4'd14) ? 14 : m_didx];
    o1 = 0;
    o2 = 0;
    emit = 1'b0;
    if (!cap_active) begin
      s = 32'(m_chan ? b : a);
      trigger_window(hi, lo);
      fire = 1'b0;
      if (trig_seen == SEEN_NONE) begin
        if (s >= hi) trig_seen = SEEN_HIGH;
        else if (s <= lo) trig_seen = SEEN_LOW;
      end else if (s >= hi) begin
        if (trig_seen == SEEN_LOW) begin
          if (!m_falling) fire = 1'b1;
          else trig_seen = SEEN_HIGH;
        end
      end else if (s <= lo) begin
        if (trig_seen == SEEN_HIGH) begin
          if (m_falling) fire = 1'b1;
          else trig_seen = SEEN_LOW;
        end
      end
      if (!fire) return;
      // capture starts on the firing pair itself
      trig_seen  = SEEN_NONE;
      cap_active = 1'b1;
      sent = 0;
      acc1 = 0;
      acc2 = 0;
      decim = m_avg ? 0 : factor;
    end

    if (!m_avg) begin
      if (decim >= factor) begin
        emit = 1'b1;
        o1 = 32'(a);
        o2 = 32'(b);
        decim = 0;
      end
      if (decim < 16'hFFFF) decim++;
    end else begin
      if (decim < 16'hFFFF) decim++;
      if (factor == 0) begin
        emit = 1'b1;
        o1 = 32'(a);
        o2 = 32'(b);
      end else if (decim >= factor) begin
        emit = 1'b1;
        o1 = (acc1 + a) / factor;
        o2 = (acc2 + b) / factor;
        if (o1 > 255) o1 = 255;   // only after a factor change mid-group
        if (o2 > 255) o2 = 255;
        decim = 0;
      end else begin
        acc1 = (acc1 + a > 24'hFFFFFF) ? 24'hFFFFFF : acc1 + a;
        acc2 = (acc2 + b > 24'hFFFFFF) ? 24'hFFFFFF : acc2 + b;
      end
    end

    if (!emit) return;
    acc1 = 0;
    acc2 = 0;
    limit = (m_cap == 0) ? 1 : m_cap;
    if (limit > MAX_PAIRS) limit = MAX_PAIRS;
    sent++;
    r.ch1  = o1[7:0];
    r.ch2  = o2[7:0];
    r.last = (sent >= limit);
    if (r.last) begin
      cap_active = 1'b0;
      trig_seen  = SEEN_NONE;
    end
    expected_q.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pair(in_tdata[7:0], in_tdata[15:8]);
        accepted_cnt++;
      end
      // an item still waiting on tready stays put
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready runs and stalls of their own random lengths, plus checking
  // --------------------------------------------------------------------------
  int ready_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    capture_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        result_cnt++;
        if (out_tlast) capture_cnt++;
        if (expected_q.size() == 0) begin
          error_cnt++;
          $display("%0t: result expected none, actual ch1=%0d ch2=%0d last=%0b",
                   $time, out_tdata[7:0], out_tdata[15:8], out_tlast);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[7:0] !== want.ch1) begin
            error_cnt++;
            $display("%0t: out_ch1 expected %0d actual %0d", $time, want.ch1, out_tdata[7:0]);
          end
          if (out_tdata[15:8] !== want.ch2) begin
            error_cnt++;
            $display("%0t: out_ch2 expected %0d actual %0d", $time, want.ch2, out_tdata[15:8]);
          end
          if (out_tlast !== want.last) begin
            error_cnt++;
            $display("%0t: last_of_capture expected %0b actual %0b",
                     $time, want.last, out_tlast);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(1, 30);
          stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Watchdog: quiet cycles with no handshake and no config write
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input sedt_pkg::cfg_reg_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all six registers; only called with the pipe drained.
  task automatic set_config(input logic chan, input logic [7:0] level, input logic falling,
                            input logic [3:0] didx, input logic avg, input logic [10:0] cap);
    m_chan    = chan;
    m_level   = level;
    m_falling = falling;
    m_didx    = didx;
    m_avg     = avg;
    m_cap     = cap;
    write_reg(sedt_pkg::CFG_TRIG_CHANNEL, cfg_data_t'(chan));
    write_reg(sedt_pkg::CFG_TRIG_LEVEL, cfg_data_t'(level));
    write_reg(sedt_pkg::CFG_TRIG_FALLING, cfg_data_t'(falling));
    write_reg(sedt_pkg::CFG_DEC_INDEX, cfg_data_t'(didx));
    write_reg(sedt_pkg::CFG_AVG_MODE, cfg_data_t'(avg));
    write_reg(sedt_pkg::CFG_CAP_PAIRS, cap);
    cfg_we <= 1'b0;
    phase_cnt++;
  endtask

  task automatic queue_pair(input logic [7:0] a, input logic [7:0] b);
    pending_q.push_back({b, a});
    pushed_cnt++;
  endtask

  // Sender holds off until every queued item is in and every result is out,
  // then lets the block finish any item that produces nothing.
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_cnt != pushed_cnt || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One pair whose trigger channel lands in the given zone
  task automatic queue_zone(input trig_zone_t zone);
    int unsigned hi, lo, v;
    trigger_window(hi, lo);
    case (zone)
      ZONE_HIGH: v = $urandom_range(255, hi);
      ZONE_LOW:  v = $urandom_range(lo, 0);
      default:   v = (hi > lo + 1) ? $urandom_range(hi - 1, lo + 1) : $urandom_range(255, 0);
    endcase
    if (m_chan) queue_pair(8'($urandom_range(255, 0)), v[7:0]);
    else        queue_pair(v[7:0], 8'($urandom_range(255, 0)));
  endtask

  // Arm zone, optional dwell in the hysteresis band, firing zone, then capture body
  task automatic queue_edge_run(input int body_len);
    queue_zone(m_falling ? ZONE_HIGH : ZONE_LOW);
    repeat ($urandom_range(0, 2)) queue_zone(ZONE_MID);
    queue_zone(m_falling ? ZONE_LOW : ZONE_HIGH);
    repeat (body_len) queue_pair(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_start, span, factor, cap_eff, r;
    logic [7:0]  lvl;
    logic [3:0]  didx;
    logic [10:0] cap;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rising edge on ch1 at the reset level, every pair kept, 3-pair capture;
    // includes the exact threshold values and an in-band sample.
    set_config(1'b0, 8'd128, 1'b0, 4'd0, 1'b0, 11'd3);
    queue_pair(8'd128, 8'd0);
    queue_pair(8'd98, 8'd0);
    queue_pair(8'd127, 8'd0);
    queue_pair(8'd128, 8'd255);
    queue_pair(8'd0, 8'd0);
    queue_pair(8'd255, 8'd255);
    wait_idle();

    // Falling edge on ch2 at level 0, averaging by 2, capture length zero
    set_config(1'b1, 8'd0, 1'b1, 4'd1, 1'b1, 11'd0);
    queue_pair(8'd10, 8'd30);
    queue_pair(8'd20, 8'd0);
    queue_pair(8'd255, 8'd255);
    wait_idle();

    // Level 255 falling (upper clamp), factor index fifteen, capture length
    // above the maximum; then shrink factor and length while capturing.
    set_config(1'b0, 8'd255, 1'b1, 4'd15, 1'b0, 11'd2047);
    queue_pair(8'd255, 8'd7);
    queue_pair(8'd254, 8'd9);
    queue_pair(8'd1, 8'd2);
    wait_idle();
    set_config(1'b0, 8'd255, 1'b1, 4'd0, 1'b0, 11'd1);
    queue_pair(8'd3, 8'd4);
    wait_idle();

    // Lower clamp on the rising window; average overflow by dropping the
    // factor from 10 to 2 in the middle of a group of full-scale pairs.
    set_config(1'b0, 8'd20, 1'b0, 4'd3, 1'b1, 11'd2);
    queue_pair(8'd0, 8'd0);
    queue_pair(8'd30, 8'd255);
    repeat (4) queue_pair(8'd255, 8'd255);
    wait_idle();
    set_config(1'b0, 8'd20, 1'b0, 4'd1, 1'b1, 11'd2);
    queue_pair(8'd255, 8'd255);
    queue_pair(8'd7, 8'd9);
    queue_pair(8'd9, 8'd9);
    wait_idle();

    // Random phases: mostly small factors and short captures, some extremes.
    rand_start = pushed_cnt;
    while (pushed_cnt - rand_start < RANDOM_ITEMS) begin
      r = $urandom_range(9, 0);
      lvl = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255, 0));
      r = $urandom_range(19, 0);
      if (r < 16)      didx = 4'($urandom_range(3, 0));
      else if (r < 19) didx = 4'($urandom_range(5, 4));
      else             didx = 4'($urandom_range(15, 6));
      r = $urandom_range(19, 0);
      case (r)
        0:       cap = 11'd0;
        1:       cap = 11'd2047;
        2:       cap = 11'd1024;
        3:       cap = 11'($urandom_range(2047, 0));
        default: cap = 11'($urandom_range(6, 1));
      endcase
      set_config(1'($urandom_range(1, 0)), lvl, 1'($urandom_range(1, 0)), didx,
                 1'($urandom_range(1, 0)), cap);

      factor  = FACTORS[(didx > 4'd14) ? 14 : didx];
      cap_eff = (cap == 0) ? 1 : (cap > MAX_PAIRS) ? MAX_PAIRS : cap;
      span    = cap_eff * ((factor == 0) ? 1 : factor) + 2;
      if (span > 40) span = 40;
      repeat ($urandom_range(5, 2)) begin
        if ($urandom_range(4, 0) == 0) begin
          // plain noise between runs
          repeat ($urandom_range(6, 1))
            queue_pair(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
        end else begin
          queue_edge_run($urandom_range(span, 0));
        end
      end
      wait_idle();
    end

    $display("Covered %0d input items over %0d register settings: %0d results, %0d captures.",
             accepted_cnt, phase_cnt, result_cnt, capture_cnt);
    $display("Both channels, both edges, sample and average modes, clamped windows.");
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> scope_edge_trigger_decimator_top.f
rtl/core/sedt_pkg.sv
rtl/core/sedt_divider.sv
rtl/core/sedt_datapath.sv
rtl/core/sedt_ctrl.sv
rtl/core/scope_edge_trigger_decimator_top.sv
test/tb.sv
